### design/nfcd_pkg.sv
// Shared constants, codes and beat types for the NOR flash command decoder.
// Used by every module of the block except nfcd_ram; depends on nothing.
package nfcd_pkg;

    // Array and sector geometry
    localparam int ADDRESS_BITS = 19;
    localparam int SECTOR_BITS  = 12;
    localparam int MATCH_BITS   = 15;

    // Unlock addresses, matched on the low address bits only
    localparam logic [MATCH_BITS-1:0] UNLOCK_A = 15'h5555;
    localparam logic [MATCH_BITS-1:0] UNLOCK_B = 15'h2AAA;

    // Command data bytes
    localparam logic [7:0] DATA_AA      = 8'hAA;
    localparam logic [7:0] DATA_55      = 8'h55;
    localparam logic [7:0] DATA_PROGRAM = 8'hA0;
    localparam logic [7:0] DATA_ERASE   = 8'h80;
    localparam logic [7:0] DATA_SECTOR  = 8'h30;
    localparam logic [7:0] ERASED_BYTE  = 8'hFF;

    // Bus command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_PROGRAM_TICKS = 1'b0;
    localparam logic CFG_ERASE_TICKS   = 1'b1;

    localparam int CFG_W        = 16;
    localparam int PROG_TICKS_W = 10;
    localparam int BUSY_W       = 16;

    localparam logic [PROG_TICKS_W-1:0] PROG_TICKS_RESET  = 10'd20;
    localparam logic [BUSY_W-1:0]       ERASE_TICKS_RESET = 16'd1250;

    // Input beat
    typedef struct packed {
        logic [1:0]              cmd;
        logic [ADDRESS_BITS-1:0] address;
        logic [7:0]              write_byte;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic [7:0] read_byte;
        logic       busy_res;
    } t_out_item;

    // Decoded action of the current input beat, command unit to sequencer
    typedef struct packed {
        logic       mem_read;   // array read needed
        logic       do_prog;    // byte program fires
        logic       do_erase;   // sector erase fires
        logic [7:0] read_byte;  // status byte, or zero when no array data
        logic       busy;       // busy before this beat
        logic       busy_res;   // busy after this beat
    } t_act;

endpackage

### design/nfcd_ram.sv
// Generic simple dual-port synchronous RAM, one write and one registered read port.
// Standalone; no package dependency.
module nfcd_ram #(
    parameter int ADDR_W = 19,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [0:(2**ADDR_W)-1];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/nfcd_cmd.sv
// Command unit: unlock sequence decoder, busy countdown, status bits, config registers.
// Depends on nfcd_pkg.
module nfcd_cmd (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  nfcd_pkg::t_in_item         i_item,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [nfcd_pkg::CFG_W-1:0] i_cfg_data,
    output nfcd_pkg::t_act             o_act
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_AA1   = 7'b0000010,
        ST_551   = 7'b0000100,
        ST_PROG  = 7'b0001000,
        ST_ERASE = 7'b0010000,
        ST_AA2   = 7'b0100000,
        ST_552   = 7'b1000000
    } t_step;

    t_step                               r_step, n_step;
    logic [nfcd_pkg::BUSY_W-1:0]         r_busy_count, n_busy_count;
    logic                                r_is_erase;
    logic                                r_toggle;
    logic                                r_prog_top;
    logic [nfcd_pkg::PROG_TICKS_W-1:0]   r_prog_ticks;
    logic [nfcd_pkg::BUSY_W-1:0]         r_erase_ticks;

    logic [nfcd_pkg::MATCH_BITS-1:0]     low_addr;
    logic [7:0]                          wdata;
    logic                                busy;
    logic                                is_write;
    logic                                is_read;
    logic                                hit_prog;
    logic                                hit_erase;
    logic                                do_prog;
    logic                                do_erase;

    // Decode the unlock sequence and the next busy count
    always_comb begin
        low_addr  = i_item.address[nfcd_pkg::MATCH_BITS-1:0];
        wdata     = i_item.write_byte;
        busy      = (r_busy_count != '0);
        is_write  = (i_item.cmd == nfcd_pkg::CMD_WRITE) && !busy;
        is_read   = (i_item.cmd == nfcd_pkg::CMD_READ);
        n_step    = ST_IDLE;
        hit_prog  = 1'b0;
        hit_erase = 1'b0;

        unique case (r_step)
            ST_IDLE: begin
                if (low_addr == nfcd_pkg::UNLOCK_A && wdata == nfcd_pkg::DATA_AA) begin
                    n_step = ST_AA1;
                end
            end
            ST_AA1: begin
                if (low_addr == nfcd_pkg::UNLOCK_B && wdata == nfcd_pkg::DATA_55) begin
                    n_step = ST_551;
                end
            end
            ST_551: begin
                if (low_addr == nfcd_pkg::UNLOCK_A && wdata == nfcd_pkg::DATA_PROGRAM) begin
                    n_step = ST_PROG;
                end else if (low_addr == nfcd_pkg::UNLOCK_A
                             && wdata == nfcd_pkg::DATA_ERASE) begin
                    n_step = ST_ERASE;
                end
            end
            ST_PROG: begin
                hit_prog = 1'b1;
            end
            ST_ERASE: begin
                if (low_addr == nfcd_pkg::UNLOCK_A && wdata == nfcd_pkg::DATA_AA) begin
                    n_step = ST_AA2;
                end
            end
            ST_AA2: begin
                if (low_addr == nfcd_pkg::UNLOCK_B && wdata == nfcd_pkg::DATA_55) begin
                    n_step = ST_552;
                end
            end
            ST_552: begin
                hit_erase = (wdata == nfcd_pkg::DATA_SECTOR);
            end
            default: begin
                n_step = ST_IDLE;
            end
        endcase

        do_prog  = is_write && hit_prog;
        do_erase = is_write && hit_erase;

        // Load on program or erase, count down on ticks while busy
        n_busy_count = r_busy_count;
        if (i_item.cmd == nfcd_pkg::CMD_TICK && busy) begin
            n_busy_count = r_busy_count - 1'b1;
        end
        if (do_prog) begin
            n_busy_count = {{(nfcd_pkg::BUSY_W - nfcd_pkg::PROG_TICKS_W){1'b0}}, r_prog_ticks};
        end
        if (do_erase) begin
            n_busy_count = r_erase_ticks;
        end

        o_act.mem_read  = is_read && !busy;
        o_act.do_prog   = do_prog;
        o_act.do_erase  = do_erase;
        o_act.read_byte = (is_read && busy)
                        ? {(~r_is_erase & ~r_prog_top), r_toggle, 6'b000000}
                        : 8'h00;
        o_act.busy      = busy;
        o_act.busy_res  = (n_busy_count != '0);
    end

    // Advance the command state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= ST_IDLE;
            r_busy_count <= '0;
            r_is_erase   <= 1'b0;
            r_toggle     <= 1'b0;
            r_prog_top   <= 1'b0;
        end else if (i_accept) begin
            r_busy_count <= n_busy_count;
            if (is_write) begin
                r_step <= n_step;
            end
            if (is_read && busy) begin
                r_toggle <= ~r_toggle;
            end
            if (do_prog) begin
                r_is_erase <= 1'b0;
                r_prog_top <= wdata[7];
            end
            if (do_erase) begin
                r_is_erase <= 1'b1;
            end
        end
    end

    // Hold the busy-time registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_ticks  <= nfcd_pkg::PROG_TICKS_RESET;
            r_erase_ticks <= nfcd_pkg::ERASE_TICKS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == nfcd_pkg::CFG_PROGRAM_TICKS) begin
                r_prog_ticks <= i_cfg_data[nfcd_pkg::PROG_TICKS_W-1:0];
            end else begin
                r_erase_ticks <= i_cfg_data;
            end
        end
    end

endmodule

### design/nor_flash_command_decoder_top.sv
// Top level of the NOR flash command decoder: array sequencer, array RAM, result register.
// Depends on nfcd_pkg, nfcd_ram and nfcd_cmd.
//
//   channel   direction  handshake                  beat
//   in        input      i_in_valid / o_in_ready    i_in   (cmd, address, write_byte)
//   out       output     o_out_valid / i_out_ready  o_out  (read_byte, busy_res)
//   cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Write, tick and status read: result registered at the accepting edge; next beat taken
//   once the result register is free. Array read: registered RAM read, then S_READ loads
//   the result. Byte program: read, then AND and write back through the single RAM.
// Sector erase: one RAM write of FF per cycle over the sector.
// After reset the array is filled with FF; input is held off meanwhile,
//   config writes are taken at any time. A stalled result holds off the next input beat.
module nor_flash_command_decoder_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  nfcd_pkg::t_in_item         i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output nfcd_pkg::t_out_item        o_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [nfcd_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int AW = nfcd_pkg::ADDRESS_BITS;
    localparam int SW = nfcd_pkg::SECTOR_BITS;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_PROG  = 5'b01000,
        S_ERASE = 5'b10000
    } t_seq;

    t_seq                r_state, n_state;
    logic [AW-1:0]       r_sweep, n_sweep;
    logic [AW-1:0]       r_addr, n_addr;
    logic [7:0]          r_wbyte, n_wbyte;
    logic                r_out_valid, n_out_valid;
    nfcd_pkg::t_out_item r_out;

    nfcd_pkg::t_act      act;
    nfcd_pkg::t_out_item out_data;
    logic                out_load;
    logic                out_free;
    logic                in_ready;
    logic                accept;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [7:0]          mem_wdata;
    logic                mem_re;
    logic [7:0]          mem_rdata;

    nfcd_cmd u_cmd (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_act       (act)
    );

    nfcd_ram #(
        .ADDR_W (AW),
        .DATA_W (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (i_in.address),
        .o_rdata (mem_rdata)
    );

    // Sequence array accesses and result loads
    always_comb begin
        out_free    = !r_out_valid || i_out_ready;
        in_ready    = (r_state == S_IDLE) && out_free;
        accept      = i_in_valid && in_ready;
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_addr      = r_addr;
        n_wbyte     = r_wbyte;
        mem_we      = 1'b0;
        mem_waddr   = r_sweep;
        mem_wdata   = nfcd_pkg::ERASED_BYTE;
        mem_re      = 1'b0;
        out_load    = 1'b0;
        out_data    = '0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we  = 1'b1;
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_addr  = i_in.address;
                    n_wbyte = i_in.write_byte;
                    if (act.mem_read) begin
                        mem_re  = 1'b1;
                        n_state = S_READ;
                    end else begin
                        out_load           = 1'b1;
                        out_data.read_byte = act.read_byte;
                        out_data.busy_res  = act.busy_res;
                        if (act.do_prog) begin
                            mem_re  = 1'b1;
                            n_state = S_PROG;
                        end
                        if (act.do_erase) begin
                            n_sweep = {i_in.address[AW-1:SW], {SW{1'b0}}};
                            n_state = S_ERASE;
                        end
                    end
                end
            end
            S_READ: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    out_data.read_byte = mem_rdata;
                    out_data.busy_res  = act.busy;
                    n_state            = S_IDLE;
                end
            end
            S_PROG: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = mem_rdata & r_wbyte;
                n_state   = S_IDLE;
            end
            S_ERASE: begin
                mem_we  = 1'b1;
                n_sweep = r_sweep + 1'b1;
                if (r_sweep[SW-1:0] == '1) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = out_load || (r_out_valid && !i_out_ready);
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_wbyte <= n_wbyte;
        if (out_load) begin
            r_out <= out_data;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

### design/nfcd_checker.sv
// Port-level checker for the NOR flash command decoder, bound to the top level.
// Depends on nfcd_pkg.
module nfcd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input nfcd_pkg::t_in_item         i_in,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input nfcd_pkg::t_out_item        o_out,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready,
    input logic                       i_cfg_index,
    input logic [nfcd_pkg::CFG_W-1:0] i_cfg_data
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    // Non-read beats give their zero result on the next cycle
    a_nonread_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.cmd != nfcd_pkg::CMD_READ
        |=> o_out_valid && o_out.read_byte == 8'h00)
        else $error("write or tick beat without zero result");

    // Reset empties the result register and starts the array fill
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("block not held off after reset");

endmodule

bind nor_flash_command_decoder_top nfcd_checker u_checker (.*);

### tb/tb_nor_flash_command_decoder_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for nor_flash_command_decoder_top: unlock sequences, programs, erases,
// status reads and busy countdowns against a cycle-free flash mirror. Depends on nfcd_pkg.
module tb_nor_flash_command_decoder_top;
    import nfcd_pkg::*;

    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = (1 << SECTOR_BITS) + 64;
    localparam int         TIMEOUT_NS    = 100_000_000;

    // Position in the unlock sequence
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_GOT_AA,
        SEQ_GOT_55,
        SEQ_PROGRAM_ARMED,
        SEQ_ERASE_ARMED,
        SEQ_ERASE_AA,
        SEQ_ERASE_55
    } t_unlock_step;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // Flash mirror and decoder state
    bit [7:0]              mirror_array [0:(1 << ADDRESS_BITS)-1];
    t_unlock_step          unlock_step;
    bit [BUSY_W-1:0]       busy_left;
    bit                    busy_erase;
    bit                    toggle;
    bit                    prog_top;
    bit [PROG_TICKS_W-1:0] prog_ticks_reg;
    bit [BUSY_W-1:0]       erase_ticks_reg;

    t_out_item expected_results [$];
    t_out_item want;
    t_in_item  cmd_seq [6];
    bit [ADDRESS_BITS-SECTOR_BITS-1:0] hot_sectors [4];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_left  = 0;
    int fail_count     = 0;
    int beats_sent     = 0;
    int results_checked = 0;
    int programs_fired = 0;
    int erases_fired   = 0;
    int reg_writes     = 0;

    nor_flash_command_decoder_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the flash mirror by one beat and return the result it produces
    function automatic t_out_item predict_flash(input t_in_item beat);
        t_out_item               res;
        t_unlock_step            nxt;
        logic [MATCH_BITS-1:0]   low;
        logic [ADDRESS_BITS-1:0] base;
        res = '0;
        low = beat.address[MATCH_BITS-1:0];
        case (beat.cmd)
            CMD_READ: begin
                if (busy_left != 0) begin
                    res.read_byte = {busy_erase ? 1'b0 : ~prog_top, toggle, 6'b0};
                    toggle = ~toggle;
                end else begin
                    res.read_byte = mirror_array[beat.address];
                end
            end
            CMD_WRITE: begin
                // Writes while busy leave the sequence untouched
                if (busy_left == 0) begin
                    nxt = SEQ_IDLE;
                    case (unlock_step)
                        SEQ_IDLE: begin
                            if (low == UNLOCK_A && beat.write_byte == DATA_AA) nxt = SEQ_GOT_AA;
                        end
                        SEQ_GOT_AA: begin
                            if (low == UNLOCK_B && beat.write_byte == DATA_55) nxt = SEQ_GOT_55;
                        end
                        SEQ_GOT_55: begin
                            if (low == UNLOCK_A && beat.write_byte == DATA_PROGRAM)
                                nxt = SEQ_PROGRAM_ARMED;
                            else if (low == UNLOCK_A && beat.write_byte == DATA_ERASE)
                                nxt = SEQ_ERASE_ARMED;
                        end
                        SEQ_PROGRAM_ARMED: begin
                            mirror_array[beat.address] = mirror_array[beat.address]
                                                         & beat.write_byte;
                            busy_left  = BUSY_W'(prog_ticks_reg);
                            busy_erase = 1'b0;
                            prog_top   = beat.write_byte[7];
                            programs_fired++;
                        end
                        SEQ_ERASE_ARMED: begin
                            if (low == UNLOCK_A && beat.write_byte == DATA_AA) nxt = SEQ_ERASE_AA;
                        end
                        SEQ_ERASE_AA: begin
                            if (low == UNLOCK_B && beat.write_byte == DATA_55) nxt = SEQ_ERASE_55;
                        end
                        SEQ_ERASE_55: begin
                            if (beat.write_byte == DATA_SECTOR) begin
                                base = {beat.address[ADDRESS_BITS-1:SECTOR_BITS],
                                        {SECTOR_BITS{1'b0}}};
                                for (int i = 0; i < (1 << SECTOR_BITS); i++)
                                    mirror_array[base + i] = ERASED_BYTE;
                                busy_left  = erase_ticks_reg;
                                busy_erase = 1'b1;
                                erases_fired++;
                            end
                        end
                        default: ;
                    endcase
                    unlock_step = nxt;
                end
            end
            CMD_TICK: begin
                if (busy_left != 0) busy_left--;
            end
            default: ;
        endcase
        res.busy_res = (busy_left != 0);
        return res;
    endfunction

    function automatic t_in_item make_beat(input logic [1:0] cmd,
                                           input logic [ADDRESS_BITS-1:0] addr,
                                           input logic [7:0] data);
        t_in_item b;
        b.cmd        = cmd;
        b.address    = addr;
        b.write_byte = data;
        return b;
    endfunction

    // Random upper bits above the matched low address bits
    function automatic logic [ADDRESS_BITS-1:0] alias_of(input logic [MATCH_BITS-1:0] low);
        logic [ADDRESS_BITS-1:0] a;
        a = ADDRESS_BITS'($urandom);
        a[MATCH_BITS-1:0] = low;
        return a;
    endfunction

    // Mostly a few hot bytes so reads see programmed data, otherwise anywhere
    function automatic logic [ADDRESS_BITS-1:0] pick_address();
        if ($urandom_range(0, 99) < 45) return ADDRESS_BITS'($urandom);
        return {hot_sectors[$urandom_range(0, 3)], SECTOR_BITS'($urandom_range(0, 15))};
    endfunction

    // Fill cmd_seq with a full program or erase sequence; return its length
    function automatic int fill_unlock(input bit erase, input logic [ADDRESS_BITS-1:0] target,
                                       input logic [7:0] data);
        cmd_seq[0] = make_beat(CMD_WRITE, alias_of(UNLOCK_A), DATA_AA);
        cmd_seq[1] = make_beat(CMD_WRITE, alias_of(UNLOCK_B), DATA_55);
        if (!erase) begin
            cmd_seq[2] = make_beat(CMD_WRITE, alias_of(UNLOCK_A), DATA_PROGRAM);
            cmd_seq[3] = make_beat(CMD_WRITE, target, data);
            return 4;
        end
        cmd_seq[2] = make_beat(CMD_WRITE, alias_of(UNLOCK_A), DATA_ERASE);
        cmd_seq[3] = make_beat(CMD_WRITE, alias_of(UNLOCK_A), DATA_AA);
        cmd_seq[4] = make_beat(CMD_WRITE, alias_of(UNLOCK_B), DATA_55);
        cmd_seq[5] = make_beat(CMD_WRITE, target, DATA_SECTOR);
        return 6;
    endfunction

    // Offer one beat after a random idle, hold it until taken, then record its result
    task automatic send_beat(input t_in_item beat);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_item  = beat;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        expected_results.push_back(predict_flash(beat));
        beats_sent++;
    endtask

    task automatic read_bus(input logic [ADDRESS_BITS-1:0] addr);
        send_beat(make_beat(CMD_READ, addr, 8'($urandom)));
    endtask

    task automatic write_bus(input logic [ADDRESS_BITS-1:0] addr, input logic [7:0] data);
        send_beat(make_beat(CMD_WRITE, addr, data));
    endtask

    task automatic tick_bus();
        send_beat(make_beat(CMD_TICK, ADDRESS_BITS'($urandom), 8'($urandom)));
    endtask

    task automatic send_unlock(input bit erase, input logic [ADDRESS_BITS-1:0] target,
                               input logic [7:0] data);
        int len;
        len = fill_unlock(erase, target, data);
        for (int k = 0; k < len; k++) send_beat(cmd_seq[k]);
    endtask

    // Count a busy period down, with an occasional status read
    task automatic tick_down(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 257 == 0) read_bus(pick_address());
            tick_bus();
        end
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_PROGRAM_TICKS) prog_ticks_reg = value[PROG_TICKS_W-1:0];
        else erase_ticks_reg = value;
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Let the block go quiet, including any sector walk, then load both counts
    task automatic reconfigure(input int prog_ticks, input int erase_ticks);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_PROGRAM_TICKS, CFG_W'(prog_ticks));
        write_reg(CFG_ERASE_TICKS, CFG_W'(erase_ticks));
    endtask

    // Mixed traffic: unlock sequences as the largest share, some broken, plus reads, ticks and noise
    task automatic run_traffic(input int n_beats);
        int       start;
        int       pick;
        int       len;
        int       stop_at;
        t_in_item wrong;
        start = beats_sent;
        for (int i = 0; i < 4; i++)
            hot_sectors[i] = (ADDRESS_BITS - SECTOR_BITS)'($urandom);
        while (beats_sent - start < n_beats) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                len = fill_unlock($urandom_range(0, 99) < 8, pick_address(), 8'($urandom));
                stop_at = ($urandom_range(0, 99) < 20) ? $urandom_range(1, len - 1) : len;
                for (int k = 0; k < stop_at; k++) begin
                    // reads and ticks in between must not disturb the sequence
                    if ($urandom_range(0, 99) < 10)
                        send_beat(make_beat($urandom_range(0, 1) ? CMD_READ : CMD_TICK,
                                            pick_address(), 8'($urandom)));
                    send_beat(cmd_seq[k]);
                end
                if (stop_at < len) begin
                    wrong = cmd_seq[stop_at];
                    if ($urandom_range(0, 1))
                        wrong.write_byte ^= 8'(1 << $urandom_range(0, 7));
                    else
                        wrong.address ^= ADDRESS_BITS'(1 << $urandom_range(0, MATCH_BITS - 1));
                    send_beat(wrong);
                end
            end else if (pick < 65) begin
                read_bus(pick_address());
            end else if (pick < 88) begin
                tick_bus();
            end else if (pick < 95) begin
                write_bus(ADDRESS_BITS'($urandom), 8'($urandom));
            end else begin
                send_beat(make_beat(CMD_UNUSED, ADDRESS_BITS'($urandom), 8'($urandom)));
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_idle_commands();
        read_bus('0);
        read_bus('1);
        send_beat(make_beat(CMD_UNUSED, '1, 8'hFF));
        tick_bus();
    endtask

    // Program with the reset count, status reads, a write ignored while busy
    task automatic test_byte_program();
        write_bus(19'h05555, DATA_AA);
        read_bus(19'h05555);
        write_bus(19'h02AAA, DATA_55);
        write_bus(19'h7D555, DATA_PROGRAM);
        write_bus('1, 8'h5A);
        read_bus('0);
        read_bus('0);
        write_bus(19'h05555, DATA_AA);
        tick_down(20);
        read_bus('1);
    endtask

    // Wrong writes drop to idle and do not start a new sequence
    task automatic test_unlock_errors();
        write_bus(19'h05555, DATA_AA);
        write_bus(19'h05555, DATA_AA);
        write_bus(19'h02AAA, DATA_55);
        write_bus(19'h05555, DATA_PROGRAM);
        write_bus('0, 8'h00);
        read_bus('0);
    endtask

    // Erase with a short count and count it all the way down
    task automatic test_sector_erase();
        reconfigure(int'(PROG_TICKS_RESET), 48);
        send_unlock(1'b1, 19'h7F123, 8'h00);
        read_bus('0);
        tick_down(48);
        read_bus('1);
    endtask

    // Zero counts update the array without ever going busy
    task automatic test_zero_busy();
        reconfigure(0, 0);
        send_unlock(1'b0, 19'h00100, 8'h0F);
        read_bus(19'h00100);
        send_unlock(1'b1, 19'h00100, 8'h00);
        read_bus(19'h00100);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int prog_ticks, input int erase_ticks,
                                       input int n_beats);
        reconfigure(prog_ticks, erase_ticks);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        run_traffic(n_beats);
    endtask

    // Hold the output off long enough to back up the input, then pause the sender
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = 400;
        run_traffic(80);
        drain_results();
        run_traffic(40);
    endtask

    // Largest counts loaded; a long erase stays busy and ignores a program meanwhile
    task automatic test_extreme_countdowns();
        reconfigure(1023, 65535);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_unlock(1'b1, pick_address(), 8'h00);
        tick_down(150);
        send_unlock(1'b0, pick_address(), 8'($urandom));
        read_bus(pick_address());
    endtask

    // Receiver: random stalls plus a counted long hold-off
    always @(negedge clk) begin
        if (hold_off_left > 0) begin
            out_ready = 1'b0;
            hold_off_left--;
        end else begin
            out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: read_byte %02h busy_res %0b",
                       out_item.read_byte, out_item.busy_res);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (out_item.read_byte !== want.read_byte) begin
                    $error("read_byte: expected %02h, actual %02h",
                           want.read_byte, out_item.read_byte);
                    fail_count++;
                end
                if (out_item.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0b, actual %0b",
                           want.busy_res, out_item.busy_res);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("nor_flash_command_decoder_top regression: fail");
        $finish;
    end

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        for (int i = 0; i < (1 << ADDRESS_BITS); i++) mirror_array[i] = ERASED_BYTE;
        unlock_step     = SEQ_IDLE;
        busy_left       = '0;
        busy_erase      = 1'b0;
        toggle          = 1'b0;
        prog_top        = 1'b0;
        prog_ticks_reg  = PROG_TICKS_RESET;
        erase_ticks_reg = ERASE_TICKS_RESET;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_idle_commands();
        test_byte_program();
        test_unlock_errors();
        test_sector_erase();
        test_zero_busy();
        test_random_traffic(0, 0, 1, 1, 225);
        test_random_traffic(75, 0, $urandom_range(2, 12), $urandom_range(1, 16), 225);
        test_random_traffic(0, 75, 6, 3, 225);
        test_random_traffic(38, 38, $urandom_range(1, 12), $urandom_range(1, 16), 225);
        test_backpressure();
        test_extreme_countdowns();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d beats, %0d results checked, %0d programs, %0d sector erases",
                 beats_sent, results_checked, programs_fired, erases_fired);
        $display("with %0d register writes, idle and stall mixes and a long output hold-off",
                 reg_writes);
        if (fail_count == 0) begin
            $display("nor_flash_command_decoder_top regression: pass");
        end else begin
            $display("nor_flash_command_decoder_top regression: fail");
        end
        $finish;
    end

endmodule

### sim.f
design/nfcd_pkg.sv
design/nfcd_ram.sv
design/nfcd_cmd.sv
design/nor_flash_command_decoder_top.sv
design/nfcd_checker.sv
tb/tb_nor_flash_command_decoder_top.sv
